### rtl/core/alu32sf_pkg.sv
// Shared types, opcodes and control structs for the 32-bit sticky-flag ALU.
package alu32sf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = $clog2(DataW);

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_ADDC = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_SUBC = 4'd3;
  localparam logic [3:0] OP_MUL  = 4'd4;
  localparam logic [3:0] OP_DIV  = 4'd6;
  localparam logic [3:0] OP_SHL  = 4'd8;
  localparam logic [3:0] OP_SHR  = 4'd9;
  localparam logic [3:0] OP_ROL  = 4'd10;
  localparam logic [3:0] OP_ROR  = 4'd11;
  localparam logic [3:0] OP_AND  = 4'd12;
  localparam logic [3:0] OP_NOT  = 4'd13;
  localparam logic [3:0] OP_OR   = 4'd14;
  localparam logic [3:0] OP_XOR  = 4'd15;

  typedef struct packed {
    logic [3:0]       kind;
    logic [DataW-1:0] base_value;
    logic [DataW-1:0] modifier_value;
  } in_beat_t;

  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic             zero_out;
    logic             negative_out;
    logic             carry_out;
    logic             overflow_out;
  } out_beat_t;

  // sequencer -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic iter;
    logic commit;
  } alu32sf_ctl_t;

  // datapath -> flag logic
  typedef struct packed {
    logic [DataW-1:0] res;
    logic             carry_hit;
    logic             base_neg;
  } alu32sf_res_t;

  function automatic logic is_multi(input logic [3:0] kind);
    return (kind == OP_MUL) || (kind == OP_DIV);
  endfunction

endpackage

### rtl/core/alu32sf_seq.sv
// Sequencer: load, single step or 32 shared-adder iterations, then commit.
module alu32sf_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  logic                        in_multi,
  input  logic                        out_free,
  output logic                        idle,
  output alu32sf_pkg::alu32sf_ctl_t   ctl
);
  import alu32sf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_ITER = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = in_multi ? S_ITER : S_EXEC;
          cnt_nxt   = CntW'(DataW - 1);
        end
      end
      S_EXEC: state_nxt = S_DONE;
      S_ITER: begin
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign idle       = (state_r == S_IDLE);
  assign ctl.load   = in_fire;
  assign ctl.exec   = (state_r == S_EXEC);
  assign ctl.iter   = (state_r == S_ITER);
  assign ctl.commit = (state_r == S_DONE) && out_free;

endmodule

### rtl/core/alu32sf_dp.sv
// Datapath: operand registers, one shared 33-bit adder, shifts and logic ops.
module alu32sf_dp (
  input  logic                        clk,
  input  alu32sf_pkg::in_beat_t       in_data,
  input  alu32sf_pkg::alu32sf_ctl_t   ctl,
  input  logic                        carry_in,
  output alu32sf_pkg::alu32sf_res_t   res
);
  import alu32sf_pkg::*;

  logic [3:0]       op_r;
  logic [DataW-1:0] a_r, b_r, acc_r, q_r;
  logic [DataW-1:0] acc_nxt, b_nxt, q_nxt, simple_res;
  logic [DataW:0]   add_x, add_y;
  logic             add_cin;
  logic [DataW+1:0] sum;
  logic             wide_shift;

  // shared adder operand select
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_cin = 1'b0;
    case (op_r)
      OP_ADD:  begin add_x = {1'b0, a_r}; add_y = {1'b0, b_r}; end
      OP_ADDC: begin add_x = {1'b0, a_r}; add_y = {1'b0, b_r}; add_cin = carry_in; end
      OP_SUB:  begin add_x = {1'b0, a_r}; add_y = {1'b1, ~b_r}; add_cin = 1'b1; end
      OP_SUBC: begin add_x = {1'b0, a_r}; add_y = {1'b1, ~b_r}; add_cin = carry_in; end
      OP_MUL: begin
        add_x = {1'b0, acc_r};
        add_y = q_r[0] ? {1'b0, b_r} : '0;
      end
      OP_DIV: begin
        // trial subtract of divisor from shifted partial remainder
        add_x   = {acc_r, q_r[DataW-1]};
        add_y   = {1'b1, ~b_r};
        add_cin = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y} + {{(DataW+1){1'b0}}, add_cin};

  assign wide_shift = |b_r[DataW-1:CntW];

  always_comb begin
    case (op_r)
      OP_ADD, OP_ADDC,
      OP_SUB, OP_SUBC: simple_res = sum[DataW-1:0];
      OP_SHL:          simple_res = wide_shift ? '0 : (a_r << b_r[CntW-1:0]);
      OP_SHR:          simple_res = wide_shift ? '0 : (a_r >> b_r[CntW-1:0]);
      OP_ROL, OP_OR:   simple_res = a_r | b_r;
      OP_ROR, OP_XOR:  simple_res = a_r ^ b_r;
      OP_AND:          simple_res = a_r & b_r;
      OP_NOT:          simple_res = ~a_r;
      default:         simple_res = '0;
    endcase
  end

  always_comb begin
    acc_nxt = acc_r;
    b_nxt   = b_r;
    q_nxt   = q_r;
    if (ctl.exec) begin
      acc_nxt = simple_res;
    end else if (ctl.iter) begin
      if (op_r == OP_MUL) begin
        acc_nxt = sum[DataW-1:0];
        b_nxt   = b_r << 1;
        q_nxt   = q_r >> 1;
      end else begin
        // sum[DataW+1] set means no borrow: quotient bit is one
        acc_nxt = sum[DataW+1] ? sum[DataW-1:0] : {acc_r[DataW-2:0], q_r[DataW-1]};
        q_nxt   = {q_r[DataW-2:0], sum[DataW+1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r  <= in_data.kind;
      a_r   <= in_data.base_value;
      acc_r <= '0;
      if (in_data.kind == OP_MUL) begin
        b_r <= in_data.base_value;
        q_r <= in_data.modifier_value;
      end else begin
        b_r <= in_data.modifier_value;
        q_r <= in_data.base_value;
      end
    end else begin
      acc_r <= acc_nxt;
      b_r   <= b_nxt;
      q_r   <= q_nxt;
    end
  end

  assign res.res       = (op_r == OP_DIV) ? q_r : acc_r;
  assign res.carry_hit = ((op_r == OP_ADD) || (op_r == OP_ADDC)) && (acc_r < a_r);
  assign res.base_neg  = a_r[DataW-1];

endmodule

### rtl/core/alu_32bit_sticky_flags.sv
// Top level: 32-bit iterative ALU with sticky flags and a registered result beat.
// Sequence: mul/div go from input beat to result through load, 32 shared-adder
//   iterations and commit; all other ops through load, one execute step and commit.
// One item in flight: a new input beat is taken only when the sequencer is idle,
//   after the previous item has committed; commit waits for a free result slot.
// Reset (rst_n low, synchronous): sequencer idle, all four flags cleared, no result.
module alu_32bit_sticky_flags (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  alu32sf_pkg::in_beat_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output alu32sf_pkg::out_beat_t out_data
);
  import alu32sf_pkg::*;

  alu32sf_ctl_t ctl;
  alu32sf_res_t dp_res;

  logic      in_fire, out_free, idle;
  logic      zero_r, neg_r, carry_r, ovf_r;
  logic      zero_nxt, neg_nxt, carry_nxt, ovf_nxt;
  logic      out_valid_r;
  out_beat_t out_r;

  // Input beat only taken when the sequencer is idle; the output register
  // lets a new item start while the previous result waits to be taken.
  assign in_ready = idle;
  assign in_fire  = in_valid && idle;
  // Result slot is free if empty or being drained this cycle.
  assign out_free = !out_valid_r || out_ready;

  alu32sf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_multi (is_multi(in_data.kind)),
    .out_free (out_free),
    .idle     (idle),
    .ctl      (ctl)
  );

  // Datapath reads the carry flag for add-with-carry / sub-with-borrow.
  alu32sf_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .ctl      (ctl),
    .carry_in (carry_r),
    .res      (dp_res)
  );

  // Sticky flags: only ever set. Overflow looks at the updated negative flag.
  assign zero_nxt  = zero_r  || (dp_res.res == '0);
  assign neg_nxt   = neg_r   || dp_res.res[DataW-1];
  assign carry_nxt = carry_r || dp_res.carry_hit;
  assign ovf_nxt   = ovf_r   || (neg_nxt && !dp_res.base_neg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r      <= 1'b0;
      neg_r       <= 1'b0;
      carry_r     <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.commit) begin
        zero_r      <= zero_nxt;
        neg_r       <= neg_nxt;
        carry_r     <= carry_nxt;
        ovf_r       <= ovf_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_r.result_value <= dp_res.res;
      out_r.zero_out     <= zero_nxt;
      out_r.negative_out <= neg_nxt;
      out_r.carry_out    <= carry_nxt;
      out_r.overflow_out <= ovf_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### dv/alu_32bit_sticky_flags_checker.sv
// Channel monitor for the sticky-flag ALU: predicts each result beat and checks it.
module alu_32bit_sticky_flags_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  alu32sf_pkg::in_beat_t  in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  alu32sf_pkg::out_beat_t out_data,
  output int                     fail_count,
  output int                     pending
);
  import alu32sf_pkg::*;

  // sticky flags as the block should hold them
  logic flag_z = 1'b0;
  logic flag_n = 1'b0;
  logic flag_c = 1'b0;
  logic flag_v = 1'b0;

  out_beat_t alu_result_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic out_beat_t run_alu_op(input in_beat_t beat);
    logic [DataW-1:0]   a;
    logic [DataW-1:0]   b;
    logic [DataW-1:0]   r;
    logic [2*DataW-1:0] prod;
    out_beat_t          res;
    a    = beat.base_value;
    b    = beat.modifier_value;
    prod = {{DataW{1'b0}}, a} * {{DataW{1'b0}}, b};
    case (beat.kind)
      OP_ADD:          r = a + b;
      OP_ADDC:         r = a + b + {{(DataW-1){1'b0}}, flag_c};
      OP_SUB:          r = a - b;
      OP_SUBC:         r = a - b - 32'd1 + {{(DataW-1){1'b0}}, flag_c};
      OP_MUL:          r = prod[DataW-1:0];
      OP_DIV:          r = (b == '0) ? '1 : a / b;
      OP_SHL:          r = (b >= DataW) ? '0 : a << b;
      OP_SHR:          r = (b >= DataW) ? '0 : a >> b;
      OP_ROL, OP_OR:   r = a | b;
      OP_ROR, OP_XOR:  r = a ^ b;
      OP_AND:          r = a & b;
      OP_NOT:          r = ~a;
      default:         r = '0;   // unused codes
    endcase
    // carry only from the add codes; overflow uses negative as it stands now
    if ((beat.kind == OP_ADD || beat.kind == OP_ADDC) && r < a) flag_c = 1'b1;
    if (r == '0) flag_z = 1'b1;
    if (r[DataW-1]) flag_n = 1'b1;
    if (flag_n && !a[DataW-1]) flag_v = 1'b1;
    res.result_value = r;
    res.zero_out     = flag_z;
    res.negative_out = flag_n;
    res.carry_out    = flag_c;
    res.overflow_out = flag_v;
    return res;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        alu_result_q.push_back(run_alu_op(in_data));
      if (out_valid && out_ready) begin
        if (alu_result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat with nothing outstanding: %h", $realtime, out_data);
        end else begin
          want = alu_result_q.pop_front();
          if (out_data.result_value !== want.result_value ||
              out_data.zero_out     !== want.zero_out     ||
              out_data.negative_out !== want.negative_out ||
              out_data.carry_out    !== want.carry_out    ||
              out_data.overflow_out !== want.overflow_out) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp %h z%b n%b c%b v%b got %h z%b n%b c%b v%b",
                       $realtime, want.result_value, want.zero_out, want.negative_out,
                       want.carry_out, want.overflow_out, out_data.result_value,
                       out_data.zero_out, out_data.negative_out, out_data.carry_out,
                       out_data.overflow_out);
          end
        end
      end
      pending <= alu_result_q.size();
    end
  end

endmodule

### dv/tb_alu_32bit_sticky_flags.sv
// Testbench top for the sticky-flag ALU: clock, reset, stimulus, back-pressure, verdict.
module tb_alu_32bit_sticky_flags;
  import alu32sf_pkg::*;

  // codes the package leaves unnamed; the block returns 0 for both
  localparam logic [3:0] OP_RSV5 = 4'd5;
  localparam logic [3:0] OP_RSV7 = 4'd7;

  localparam int NumRandom     = 2000;
  localparam int CalmTail      = 300;   // last beats run with no idling on either side
  localparam int HoldOffCycles = 300;   // long receiver stall, well past one mul/div
  localparam int DrainCycles   = 40;    // wait after the final drain, before the verdict

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_beat_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_beat_t out_data;

  int fail_count;
  int pending;

  bit no_idle      = 1'b0;
  bit hold_off_req = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  alu_32bit_sticky_flags uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  alu_32bit_sticky_flags_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog: a timeout far beyond the slowest legal run.
  initial begin
    #12_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver. Random stall bursts, a single long hold-off on request,
  // and steady ready once the calm tail begins. One NBA to out_ready per edge.
  always begin
    @(posedge clk);
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      out_ready <= 1'b0;
      repeat (HoldOffCycles) @(posedge clk);
      out_ready <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one beat and block until it is taken. An idle gap, if any, comes first,
  // so valid only drops between beats and never inside one handshake.
  task automatic send_op(input logic [3:0] kind, input logic [31:0] a,
                         input logic [31:0] b);
    in_beat_t beat;
    beat.kind           = kind;
    beat.base_value     = a;
    beat.modifier_value = b;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // Operand mix: corner values, small values, and full-width random words.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // Wait until every predicted result has come back. The first edge lets the
  // checker's count catch up with a beat accepted on this same edge.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [3:0]  kind;
    logic [31:0] a;
    logic [31:0] b;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Flags are sticky and reset happens once, so the order matters:
    // first ops that leave every flag clear (add/sub with carry clear too), then
    // zero, carry, negative and overflow get set one after another.
    send_op(OP_ADD,  32'd1,     32'd2);
    send_op(OP_ADDC, 32'd5,     32'd6);
    send_op(OP_SUBC, 32'd10,    32'd3);
    send_op(OP_SUB,  32'd9,     32'd4);
    send_op(OP_MUL,  32'd12345, 32'd6789);
    send_op(OP_DIV,  32'd1000,  32'd7);
    send_op(OP_SHL,  32'd3,     32'd4);
    send_op(OP_SHR,  32'h7FFF_FFFF, 32'd30);
    send_op(OP_ROL,  32'h0000_0F00, 32'h0000_00F0);
    send_op(OP_ROR,  32'h0000_0FF0, 32'h0000_00FF);
    send_op(OP_AND,  32'h0000_0F0F, 32'h0000_00FF);
    send_op(OP_OR,   32'h0000_1000, 32'h0000_0001);
    send_op(OP_XOR,  32'h0000_5555, 32'h0000_AAAA);
    // unused codes give 0, which sets zero
    send_op(OP_RSV5, 32'h1234_5678, 32'h9ABC_DEF0);
    send_op(OP_RSV7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // add wrap sets carry; add-with-carry and sub-with-borrow then see it set
    send_op(OP_ADD,  32'hFFFF_FFFF, 32'd1);
    send_op(OP_ADDC, 32'hFFFF_FFFF, 32'd0);
    send_op(OP_SUBC, 32'd0,         32'd0);
    send_op(OP_NOT,  32'h8000_0000, 32'hFFFF_FFFF);
    // wide shifts give 0
    send_op(OP_SHL,  32'hFFFF_FFFF, 32'd32);
    send_op(OP_SHR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // sign bit from a positive base: negative and overflow
    send_op(OP_SHL,  32'd1,         32'd31);
    // divide by zero gives all ones; extreme mul/div
    send_op(OP_DIV,  32'hFFFF_FFFF, 32'd0);
    send_op(OP_DIV,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_MUL,  32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Random part
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom - CalmTail) no_idle = 1'b1;
      // receiver stalls long while beats keep coming, so the block backs up
      if (i == 600) hold_off_req = 1'b1;
      // sender goes quiet until the block is empty
      if (i == 1200) drain();
      kind = 4'($urandom_range(0, 15));
      a    = pick_operand();
      case (kind)
        OP_SHL, OP_SHR: b = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 40);
        OP_DIV: begin
          case ($urandom_range(0, 3))
            0:       b = 32'd0;
            1:       b = $urandom_range(1, 1000);
            default: b = pick_operand();
          endcase
        end
        default: b = pick_operand();
      endcase
      send_op(kind, a, b);
    end

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### alu_32bit_sticky_flags.f
rtl/core/alu32sf_pkg.sv
rtl/core/alu32sf_seq.sv
rtl/core/alu32sf_dp.sv
rtl/core/alu_32bit_sticky_flags.sv
dv/alu_32bit_sticky_flags_checker.sv
dv/tb_alu_32bit_sticky_flags.sv
